// ===== rtl/gray_rect_fill_packed_framebuffer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packed gray frame buffer.
// The macros wrap concurrent checks that are clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GRAY_RECT_FILL_PACKED_FRAMEBUFFER_DEFINES_SVH
`define GRAY_RECT_FILL_PACKED_FRAMEBUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRFB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grfb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GRFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grfb: next-cycle check failed");

`endif

// ===== rtl/grfb_pkg.sv =====
// ----------------------------------------------------------------------------
// grfb_pkg
// Screen geometry, field widths and the command and status bundles shared by
// the controller and the datapath of the packed gray frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package grfb_pkg;

   // Screen geometry.
   localparam int SCREEN_WIDTH  = 256;
   localparam int SCREEN_HEIGHT = 64;
   localparam int WORDS_PER_ROW = (SCREEN_WIDTH + 3) / 4;
   localparam int STORE_DEPTH   = WORDS_PER_ROW * SCREEN_HEIGHT;
   localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Field widths.
   localparam int COORD_W = 10;
   localparam int RGB_W   = 24;
   localparam int GRAY_W  = 4;
   localparam int WORD_W  = 16;

   // Function codes.
   localparam logic FUNC_FILL = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;      // write zero at the clearing address and step it
      logic load;       // capture the incoming transaction
      logic mem_rd;     // read the word of the current pixel
      logic mem_wr;     // write the merged word of the current pixel
      logic advance;    // step to the next pixel of the rectangle
      logic rsp_load;   // load the result register
   } grfb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // clearing address is at the last word
      logic req_read;    // incoming transaction is a pixel read
      logic req_skip;    // incoming transaction touches no pixel
      logic is_read;     // captured transaction is a pixel read
      logic last_pixel;  // current pixel is the last one of the rectangle
      logic rsp_busy;    // result register is full and not being taken
   } grfb_status_type;

endpackage

`default_nettype wire

// ===== rtl/grfb_if.sv =====
// ----------------------------------------------------------------------------
// grfb_if
// Valid/ready channels of the packed gray frame buffer: the request channel
// and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface grfb_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [grfb_pkg::COORD_W-1:0]   x_first;
   logic [grfb_pkg::COORD_W-1:0]   y_first;
   logic [grfb_pkg::COORD_W-1:0]   x_last;
   logic [grfb_pkg::COORD_W-1:0]   y_last;
   logic [grfb_pkg::RGB_W-1:0]     rgb_colour;

   modport source (output valid, func, x_first, y_first, x_last, y_last, rgb_colour,
                   input ready);
   modport sink   (input valid, func, x_first, y_first, x_last, y_last, rgb_colour,
                   output ready);
endinterface

interface grfb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [grfb_pkg::GRAY_W-1:0]   gray_value;
   logic                          coord_inside;

   modport source (output valid, gray_value, coord_inside, input ready);
   modport sink   (input valid, gray_value, coord_inside, output ready);
endinterface

`default_nettype wire

// ===== rtl/gray_rect_fill_packed_framebuffer.sv =====
// ----------------------------------------------------------------------------
// gray_rect_fill_packed_framebuffer
// Frame store of 4-bit gray pixels packed four to a 16-bit word, with a
// rectangle fill by read-modify-write and a single-pixel read.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake      Transaction
//   req_ch    in          valid/ready    fill a rectangle or read one pixel
//   rsp_ch    out         valid/ready    gray level and on-screen flag
//
// A fill reads and writes the word of each on-screen pixel of the clipped rectangle
// in turn; a read reads the word of its pixel once, and a read off the screen or a
// fill that touches no pixel goes from intake straight to the result. The frame
// store has a single port: each pixel needs one read and one write of its word.
// After reset a clearing pass writes zero to all 4096 words, one per cycle,
// before the first transaction is accepted.
// A stalled response holds the finished result; a finished transaction waits
// until the result register has room, and the next request is taken after it.
//
`default_nettype none

module gray_rect_fill_packed_framebuffer (
   input  wire logic  clock,
   input  wire logic  reset,
   grfb_req_if.sink   req_ch,
   grfb_rsp_if.source rsp_ch
);

   grfb_pkg::grfb_cmd_type    cmd;
   grfb_pkg::grfb_status_type st;

   // Sequencing of the clearing pass, the sweep and the result hand-off.
   grfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Frame store, coordinates and result register.
   grfb_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .st     (st)
   );

endmodule

`default_nettype wire

// ===== rtl/grfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// grfb_ctrl
// Controller of the packed gray frame buffer: clearing pass after reset,
// transaction intake, read-modify-write sweep of a rectangle and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module grfb_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire grfb_pkg::grfb_status_type st,
   output grfb_pkg::grfb_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RD    = 5'b00100,
      ST_WR    = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = st.req_skip ? ST_DONE : ST_RD;
            end
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = st.is_read ? ST_DONE : ST_WR;
         end
         ST_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.advance = 1'b1;
            state_in    = st.last_pixel ? ST_DONE : ST_RD;
         end
         ST_DONE: begin
            if (!st.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/grfb_datapath.sv =====
// ----------------------------------------------------------------------------
// grfb_datapath
// Datapath of the packed gray frame buffer: the frame store, the pixel
// coordinate counters, the nibble merge and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gray_rect_fill_packed_framebuffer_defines.svh"

module grfb_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   grfb_req_if.sink                    req_ch,
   grfb_rsp_if.source                  rsp_ch,
   input  wire grfb_pkg::grfb_cmd_type cmd,
   output grfb_pkg::grfb_status_type   st
);

   localparam logic [grfb_pkg::COORD_W-1:0] X_MAX =
      grfb_pkg::COORD_W'(grfb_pkg::SCREEN_WIDTH - 1);
   localparam logic [grfb_pkg::COORD_W-1:0] Y_MAX =
      grfb_pkg::COORD_W'(grfb_pkg::SCREEN_HEIGHT - 1);
   localparam logic [grfb_pkg::ADDR_W-1:0] ADDR_LAST =
      grfb_pkg::ADDR_W'(grfb_pkg::STORE_DEPTH - 1);

   // Frame store and its registered read data.
   logic [grfb_pkg::WORD_W-1:0] pixel_store_ff [grfb_pkg::STORE_DEPTH];
   logic [grfb_pkg::WORD_W-1:0] rd_data_ff;

   // Clearing address.
   logic [grfb_pkg::ADDR_W-1:0] clr_addr_ff;
   logic [grfb_pkg::ADDR_W-1:0] clr_addr_in;

   // Captured transaction.
   logic                          func_ff;
   logic                          skip_ff;
   logic [grfb_pkg::COORD_W-1:0]  x0_ff;
   logic [grfb_pkg::COORD_W-1:0]  x_ff;
   logic [grfb_pkg::COORD_W-1:0]  y_ff;
   logic [grfb_pkg::COORD_W-1:0]  xl_ff;
   logic [grfb_pkg::COORD_W-1:0]  yl_ff;
   logic [grfb_pkg::GRAY_W-1:0]   gray_ff;

   // Result register.
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [grfb_pkg::GRAY_W-1:0]   rsp_gray_ff;
   logic                          rsp_inside_ff;

   // Combinational terms.
   logic [grfb_pkg::COORD_W-1:0]  req_xl;
   logic [grfb_pkg::COORD_W-1:0]  req_yl;
   logic                          req_fill_skip;
   logic                          req_read_off;
   logic [grfb_pkg::GRAY_W-1:0]   req_gray;
   logic [grfb_pkg::ADDR_W-1:0]   pix_addr;
   logic [grfb_pkg::ADDR_W-1:0]   mem_addr;
   logic                          mem_we;
   logic [grfb_pkg::WORD_W-1:0]   mem_wdata;
   logic [1:0]                    nib_sel;
   logic [grfb_pkg::WORD_W-1:0]   merged;
   logic [grfb_pkg::GRAY_W-1:0]   read_nib;
   logic                          x_at_end;

   // Gray level of the colour: the largest of the three upper nibbles.
   always_comb begin
      req_gray = req_ch.rgb_colour[7:4];
      if (req_gray < req_ch.rgb_colour[15:12]) begin
         req_gray = req_ch.rgb_colour[15:12];
      end
      if (req_gray < req_ch.rgb_colour[23:20]) begin
         req_gray = req_ch.rgb_colour[23:20];
      end
   end

   // Clip the far corner to the screen and find transactions that touch no pixel.
   assign req_xl        = (req_ch.x_last > X_MAX) ? X_MAX : req_ch.x_last;
   assign req_yl        = (req_ch.y_last > Y_MAX) ? Y_MAX : req_ch.y_last;
   assign req_fill_skip = (req_ch.x_first > req_xl) || (req_ch.y_first > req_yl);
   assign req_read_off  = (req_ch.x_first > X_MAX) || (req_ch.y_first > Y_MAX);

   // Word address of the current pixel; pixel zero of a word sits in its top nibble.
   assign pix_addr = grfb_pkg::ADDR_W'(32'(y_ff) * 32'(grfb_pkg::WORDS_PER_ROW)
                                       + 32'(x_ff >> 2));
   assign nib_sel  = ~x_ff[1:0];

   // Replace the nibble of the current pixel in the word just read.
   always_comb begin
      merged = rd_data_ff;
      for (int i = 0; i < 4; i++) begin
         if (nib_sel == 2'(i)) begin
            merged[i*grfb_pkg::GRAY_W +: grfb_pkg::GRAY_W] = gray_ff;
         end
      end
   end

   // Nibble of the pixel that is read back.
   always_comb begin
      read_nib = '0;
      for (int i = 0; i < 4; i++) begin
         if (nib_sel == 2'(i)) begin
            read_nib = rd_data_ff[i*grfb_pkg::GRAY_W +: grfb_pkg::GRAY_W];
         end
      end
   end

   // Memory port selection between the clearing pass and the sweep.
   assign mem_addr  = cmd.clear ? clr_addr_ff : pix_addr;
   assign mem_we    = cmd.clear || cmd.mem_wr;
   assign mem_wdata = cmd.clear ? '0 : merged;

   // Frame store with one port and registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_store_ff[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= pixel_store_ff[mem_addr];
      end
   end

   // Clearing address counter.
   assign clr_addr_in = cmd.clear ? clr_addr_ff + 1'b1 : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Capture the transaction and step through the rectangle row by row.
   assign x_at_end = (x_ff == xl_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_ch.func;
         skip_ff <= (req_ch.func == grfb_pkg::FUNC_READ) ? req_read_off : req_fill_skip;
         x0_ff   <= req_ch.x_first;
         x_ff    <= req_ch.x_first;
         y_ff    <= req_ch.y_first;
         xl_ff   <= req_xl;
         yl_ff   <= req_yl;
         gray_ff <= req_gray;
      end else if (cmd.advance) begin
         if (x_at_end) begin
            x_ff <= x0_ff;
            y_ff <= y_ff + 1'b1;
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

   // Result register: refilled only when empty or when the previous result is being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (func_ff == grfb_pkg::FUNC_READ) begin
            rsp_gray_ff   <= skip_ff ? '0 : read_nib;
            rsp_inside_ff <= !skip_ff;
         end else begin
            rsp_gray_ff   <= '0;
            rsp_inside_ff <= 1'b1;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.gray_value   = rsp_gray_ff;
   assign rsp_ch.coord_inside = rsp_inside_ff;

   // Status toward the controller.
   assign st.clear_last = (clr_addr_ff == ADDR_LAST);
   assign st.req_read   = (req_ch.func == grfb_pkg::FUNC_READ);
   assign st.req_skip   = st.req_read ? req_read_off : req_fill_skip;
   assign st.is_read    = (func_ff == grfb_pkg::FUNC_READ);
   assign st.last_pixel = x_at_end && (y_ff == yl_ff);
   assign st.rsp_busy   = rsp_valid_ff && !rsp_ch.ready;

   // A result never overwrites one that is still waiting.
   `GRFB_ASSERT_IMPL(a_rsp_no_overwrite, clock, reset, cmd.rsp_load, !(rsp_valid_ff && !rsp_ch.ready))
   // Pixel writes stay on the screen.
   `GRFB_ASSERT_IMPL(a_wr_on_screen, clock, reset, cmd.mem_wr, (x_ff <= X_MAX) && (y_ff <= Y_MAX))
   // The sweep never steps past the far corner of the rectangle.
   `GRFB_ASSERT_IMPL(a_sweep_bounds, clock, reset, cmd.advance, (x_ff <= xl_ff) && (y_ff <= yl_ff))
   // Every word read is followed by its write or by the result, not another read.
   `GRFB_ASSERT_NEXT(a_rd_then_use, clock, reset, cmd.mem_rd, !cmd.mem_rd && !cmd.clear)

endmodule

`default_nettype wire
